>>> rtl/kbse_pkg.sv
// Shared types and constants for the keyframe Bezier spline engine.
// No dependencies; used by kbse_ctrl, kbse_dp and the top level.
package kbse_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   typedef enum logic [2:0] {
      OP_ADD_POINT  = 3'd0,
      OP_SET_VALUE  = 3'd1,
      OP_SET_SEG    = 3'd2,
      OP_SET_CORNER = 3'd3,
      OP_EVALUATE   = 3'd4,
      OP_READ_TYPES = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      SEG_LINEAR = 2'd0,
      SEG_QUAD   = 2'd1,
      SEG_CUBIC  = 2'd2
   } seg_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // address relative to the addressed point, or the append slot
   typedef enum logic [1:0] {
      AD_I   = 2'd0,
      AD_IP1 = 2'd1,
      AD_IM1 = 2'd2,
      AD_CNT = 2'd3
   } addr_sel_type;

   typedef enum logic [2:0] {
      SRC_PV_I   = 3'd0,
      SRC_PV_IP1 = 3'd1,
      SRC_PV_IM1 = 3'd2,
      SRC_SUM_OH = 3'd3,
      SRC_SUM_IH = 3'd4
   } src_type;

   typedef struct packed {
      logic         take_req;
      addr_sel_type rd_sel;
      logic         cap_i;
      logic         cap_ip1;
      logic         cap_im1;
      logic         calc_delta;
      logic         calc_sum;
      logic         status_we;
      status_type   status_val;
      logic         pv_we;
      addr_sel_type pv_wa;
      logic         sk_we;
      addr_sel_type sk_wa;
      logic [1:0]   sk_wd;
      logic         ck_we;
      addr_sel_type ck_wa;
      logic         ck_wd;
      logic         cnt_inc;
      logic         oh_we;
      addr_sel_type oh_wa;
      src_type      oh_src;
      logic         ih_we;
      addr_sel_type ih_wa;
      src_type      ih_src;
      logic         load_ctl;
      logic         mul;
      logic         add;
      logic [1:0]   lane;
      logic         res_set;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] kind;
      logic       point_ok;
      logic       seg_ok;
      logic       i_zero;
      logic       full;
      logic [1:0] sk_i;
      logic [1:0] sk_im1;
      logic       ck_i;
   } flags_type;

endpackage

>>> rtl/keyframe_bezier_spline_engine.sv
// Keyframe Bezier spline engine, top level: controller plus datapath.
// Depends on kbse_pkg, kbse_ctrl and kbse_dp.
//
// One request is worked on at a time and gives exactly one response. Set value
// and smooth corner go through a second table-write state, as their handle
// updates need a second write to the one-write-port tables. Evaluate runs 1, 3
// or 6 lerps for a linear, quadratic or cubic segment: every lerp goes through
// the one shared multiplier, with the product registered and the sum made in
// the next cycle. A new request is taken while the last response still waits.
// No clearing pass runs after reset.
module keyframe_bezier_spline_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_opcode,
   input  logic [kbse_pkg::IDX_W-1:0]       req_point_index,
   input  logic signed [31:0]               req_value_in,
   input  logic [16:0]                      req_position,
   input  logic [1:0]                       req_kind,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [31:0]               rsp_curve_value,
   output logic [1:0]                       rsp_segment_kind_out,
   output logic                             rsp_corner_kind_out,
   output logic [kbse_pkg::CNT_W-1:0]       rsp_point_total,
   output logic [1:0]                       rsp_status
);

   kbse_pkg::cmd_type   cmd;
   kbse_pkg::flags_type flags;

   kbse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   kbse_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .flags                (flags),
      .req_opcode           (req_opcode),
      .req_point_index      (req_point_index),
      .req_value_in         (req_value_in),
      .req_position         (req_position),
      .req_kind             (req_kind),
      .rsp_curve_value      (rsp_curve_value),
      .rsp_segment_kind_out (rsp_segment_kind_out),
      .rsp_corner_kind_out  (rsp_corner_kind_out),
      .rsp_point_total      (rsp_point_total),
      .rsp_status           (rsp_status)
   );

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_point_total <= kbse_pkg::CNT_W'(kbse_pkg::MAX_POINTS))
      else $error("point total beyond table size");

   a_full_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == kbse_pkg::ST_FULL |->
         rsp_point_total == kbse_pkg::CNT_W'(kbse_pkg::MAX_POINTS))
      else $error("table full reported with room left");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != kbse_pkg::ST_OK |-> rsp_curve_value == 32'sd0)
      else $error("nonzero curve value on error");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

>>> rtl/kbse_ctrl.sv
// Sequencer for the keyframe Bezier spline engine.
// Depends on kbse_pkg; drives kbse_dp through cmd_type and reads flags_type.
module kbse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  kbse_pkg::flags_type flags,
   output kbse_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_EXEC, S_WR1, S_WR2,
      S_LOAD, S_MUL, S_ADD, S_FIN, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] m_ff, m_in;
   logic [1:0] j_ff, j_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      m_in     = m_ff;
      j_in     = j_ff;
      cmd.rd_sel = kbse_pkg::AD_I;
      case (state_ff)
         S_IDLE: begin
            cmd.take_req = req_valid;
            if (req_valid) begin
               state_in = S_RD0;
            end
         end
         S_RD0: begin
            state_in = S_RD1;
         end
         S_RD1: begin
            cmd.cap_i  = 1'b1;
            cmd.rd_sel = kbse_pkg::AD_IP1;
            state_in   = S_RD2;
         end
         S_RD2: begin
            cmd.cap_ip1    = 1'b1;
            cmd.calc_delta = 1'b1;
            cmd.rd_sel     = kbse_pkg::AD_IM1;
            state_in       = S_RD3;
         end
         S_RD3: begin
            cmd.cap_im1  = 1'b1;
            cmd.calc_sum = 1'b1;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FIN;
            case (flags.op)
               kbse_pkg::OP_ADD_POINT: begin
                  if (flags.full) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = kbse_pkg::ST_FULL;
                  end else begin
                     state_in = S_WR1;
                  end
               end
               kbse_pkg::OP_SET_VALUE: begin
                  if (!flags.point_ok) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = kbse_pkg::ST_RANGE;
                  end else begin
                     state_in = S_WR1;
                  end
               end
               kbse_pkg::OP_SET_SEG: begin
                  if (!flags.seg_ok) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = kbse_pkg::ST_RANGE;
                  end else begin
                     state_in = S_WR1;
                  end
               end
               kbse_pkg::OP_SET_CORNER: begin
                  if (!flags.point_ok) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = kbse_pkg::ST_RANGE;
                  end else if (flags.kind <= 2'd1 && flags.ck_i != flags.kind[0]) begin
                     state_in = S_WR1;
                  end
               end
               kbse_pkg::OP_EVALUATE: begin
                  if (!flags.seg_ok) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = kbse_pkg::ST_RANGE;
                  end else begin
                     state_in = S_LOAD;
                  end
               end
               kbse_pkg::OP_READ_TYPES: begin
                  if (!flags.point_ok) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = kbse_pkg::ST_RANGE;
                  end
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_WR1: begin
            state_in = S_FIN;
            case (flags.op)
               kbse_pkg::OP_ADD_POINT: begin
                  cmd.pv_we   = 1'b1;
                  cmd.pv_wa   = kbse_pkg::AD_CNT;
                  cmd.sk_we   = 1'b1;
                  cmd.sk_wa   = kbse_pkg::AD_CNT;
                  cmd.sk_wd   = kbse_pkg::SEG_LINEAR;
                  cmd.ck_we   = 1'b1;
                  cmd.ck_wa   = kbse_pkg::AD_CNT;
                  cmd.ck_wd   = 1'b0;
                  cmd.cnt_inc = 1'b1;
               end
               kbse_pkg::OP_SET_VALUE: begin
                  cmd.pv_we = 1'b1;
                  cmd.pv_wa = kbse_pkg::AD_I;
                  if (flags.seg_ok && flags.sk_i != kbse_pkg::SEG_LINEAR) begin
                     cmd.oh_we  = 1'b1;
                     cmd.oh_wa  = kbse_pkg::AD_I;
                     cmd.oh_src = kbse_pkg::SRC_SUM_OH;
                     if (flags.sk_i == kbse_pkg::SEG_QUAD) begin
                        cmd.ih_we  = 1'b1;
                        cmd.ih_wa  = kbse_pkg::AD_IP1;
                        cmd.ih_src = kbse_pkg::SRC_SUM_OH;
                     end
                  end
                  state_in = S_WR2;
               end
               kbse_pkg::OP_SET_SEG: begin
                  case (flags.kind)
                     kbse_pkg::SEG_LINEAR: begin
                        cmd.sk_we = 1'b1;
                        cmd.sk_wa = kbse_pkg::AD_I;
                        cmd.sk_wd = kbse_pkg::SEG_LINEAR;
                     end
                     kbse_pkg::SEG_QUAD: begin
                        cmd.sk_we  = 1'b1;
                        cmd.sk_wa  = kbse_pkg::AD_I;
                        cmd.sk_wd  = kbse_pkg::SEG_QUAD;
                        cmd.oh_we  = 1'b1;
                        cmd.oh_wa  = kbse_pkg::AD_I;
                        cmd.oh_src = kbse_pkg::SRC_PV_I;
                        cmd.ih_we  = 1'b1;
                        cmd.ih_wa  = kbse_pkg::AD_IP1;
                        cmd.ih_src = kbse_pkg::SRC_PV_I;
                     end
                     kbse_pkg::SEG_CUBIC: begin
                        cmd.sk_we  = 1'b1;
                        cmd.sk_wa  = kbse_pkg::AD_I;
                        cmd.sk_wd  = kbse_pkg::SEG_CUBIC;
                        cmd.oh_we  = 1'b1;
                        cmd.oh_wa  = kbse_pkg::AD_I;
                        cmd.oh_src = kbse_pkg::SRC_PV_I;
                        cmd.ih_we  = 1'b1;
                        cmd.ih_wa  = kbse_pkg::AD_IP1;
                        cmd.ih_src = kbse_pkg::SRC_PV_IP1;
                     end
                     default: begin
                        cmd.sk_we = 1'b0;
                     end
                  endcase
               end
               kbse_pkg::OP_SET_CORNER: begin
                  cmd.ck_we = 1'b1;
                  cmd.ck_wa = kbse_pkg::AD_I;
                  cmd.ck_wd = flags.kind[0];
                  if (flags.kind[0]) begin
                     state_in = S_WR2;
                     // left neighbor becomes cubic, in handle snaps to the point
                     if (!flags.i_zero) begin
                        cmd.ih_we  = 1'b1;
                        cmd.ih_wa  = kbse_pkg::AD_I;
                        cmd.ih_src = kbse_pkg::SRC_PV_I;
                        if (flags.sk_im1 != kbse_pkg::SEG_CUBIC) begin
                           cmd.sk_we  = 1'b1;
                           cmd.sk_wa  = kbse_pkg::AD_IM1;
                           cmd.sk_wd  = kbse_pkg::SEG_CUBIC;
                           cmd.oh_we  = 1'b1;
                           cmd.oh_wa  = kbse_pkg::AD_IM1;
                           cmd.oh_src = kbse_pkg::SRC_PV_IM1;
                        end
                     end
                  end
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_WR2: begin
            state_in = S_FIN;
            if (flags.op == kbse_pkg::OP_SET_VALUE) begin
               if (!flags.i_zero && flags.sk_im1 != kbse_pkg::SEG_LINEAR) begin
                  cmd.ih_we  = 1'b1;
                  cmd.ih_wa  = kbse_pkg::AD_I;
                  cmd.ih_src = kbse_pkg::SRC_SUM_IH;
                  if (flags.sk_im1 == kbse_pkg::SEG_QUAD) begin
                     cmd.oh_we  = 1'b1;
                     cmd.oh_wa  = kbse_pkg::AD_IM1;
                     cmd.oh_src = kbse_pkg::SRC_SUM_IH;
                  end
               end
            end else if (flags.seg_ok) begin
               // right neighbor of a smooth corner
               cmd.oh_we  = 1'b1;
               cmd.oh_wa  = kbse_pkg::AD_I;
               cmd.oh_src = kbse_pkg::SRC_PV_I;
               if (flags.sk_i != kbse_pkg::SEG_CUBIC) begin
                  cmd.sk_we  = 1'b1;
                  cmd.sk_wa  = kbse_pkg::AD_I;
                  cmd.sk_wd  = kbse_pkg::SEG_CUBIC;
                  cmd.ih_we  = 1'b1;
                  cmd.ih_wa  = kbse_pkg::AD_IP1;
                  cmd.ih_src = kbse_pkg::SRC_PV_IP1;
               end
            end
         end
         S_LOAD: begin
            cmd.load_ctl = 1'b1;
            j_in = 2'd0;
            case (flags.sk_i)
               kbse_pkg::SEG_QUAD:  m_in = 2'd2;
               kbse_pkg::SEG_CUBIC: m_in = 2'd3;
               default:             m_in = 2'd1;
            endcase
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            cmd.lane = j_ff;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            cmd.lane = j_ff;
            state_in = S_MUL;
            // advance along the level, then drop one level
            if (j_ff + 2'd1 < m_ff) begin
               j_in = j_ff + 2'd1;
            end else if (m_ff > 2'd1) begin
               m_in = m_ff - 2'd1;
               j_in = 2'd0;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.res_set = (flags.op == kbse_pkg::OP_EVALUATE) && flags.seg_ok;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         m_ff         <= 2'd0;
         j_ff         <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         m_ff         <= m_in;
         j_ff         <= j_in;
      end
   end

endmodule

>>> rtl/kbse_dp.sv
// Datapath of the keyframe Bezier spline engine: point tables, handle
// arithmetic and the shared lerp unit. Depends on kbse_pkg.
module kbse_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  kbse_pkg::cmd_type                cmd,
   output kbse_pkg::flags_type              flags,
   input  logic [2:0]                       req_opcode,
   input  logic [kbse_pkg::IDX_W-1:0]       req_point_index,
   input  logic signed [31:0]               req_value_in,
   input  logic [16:0]                      req_position,
   input  logic [1:0]                       req_kind,
   output logic signed [31:0]               rsp_curve_value,
   output logic [1:0]                       rsp_segment_kind_out,
   output logic                             rsp_corner_kind_out,
   output logic [kbse_pkg::CNT_W-1:0]       rsp_point_total,
   output logic [1:0]                       rsp_status
);

   localparam int IW = kbse_pkg::IDX_W;
   localparam int CW = kbse_pkg::CNT_W;
   localparam logic [16:0] T_ONE = 17'd65536;

   logic signed [31:0] pv_mem [kbse_pkg::MAX_POINTS];
   logic signed [31:0] oh_mem [kbse_pkg::MAX_POINTS];
   logic signed [31:0] ih_mem [kbse_pkg::MAX_POINTS];
   logic [1:0]         sk_mem [kbse_pkg::MAX_POINTS];
   logic               ck_mem [kbse_pkg::MAX_POINTS];

   logic signed [31:0] pv_rd_ff, oh_rd_ff, ih_rd_ff;
   logic [1:0]         sk_rd_ff;
   logic               ck_rd_ff;

   logic [2:0]         op_ff;
   logic [IW-1:0]      idx_ff;
   logic signed [31:0] val_ff;
   logic [16:0]        t_ff;
   logic [1:0]         kind_ff;
   logic [CW-1:0]      cnt_ff, cnt_in;

   logic signed [31:0] pv_i_ff, oh_i_ff, ih_i_ff, pv_ip1_ff, ih_ip1_ff, pv_im1_ff;
   logic [1:0]         sk_i_ff, sk_im1_ff;
   logic               ck_i_ff;
   logic signed [32:0] delta_ff;
   logic signed [31:0] sum_oh_ff, sum_ih_ff;

   logic signed [31:0] c0_ff, c1_ff, c2_ff, c3_ff;
   logic signed [31:0] lo_val, hi_val, add_val;
   logic signed [50:0] prod_ff, prod_in;
   logic signed [32:0] diff;

   logic signed [31:0] result_ff;
   logic [1:0]         status_ff;

   logic signed [31:0] rsp_curve_ff;
   logic [1:0]         rsp_sk_ff, rsp_status_ff;
   logic               rsp_ck_ff;
   logic [CW-1:0]      rsp_total_ff;

   logic [IW-1:0]      rd_addr;
   logic               point_ok;

   function automatic logic [IW-1:0] addr_of(kbse_pkg::addr_sel_type sel,
                                             logic [IW-1:0] i,
                                             logic [CW-1:0] cnt);
      case (sel)
         kbse_pkg::AD_IP1: addr_of = i + IW'(1);
         kbse_pkg::AD_IM1: addr_of = i - IW'(1);
         kbse_pkg::AD_CNT: addr_of = cnt[IW-1:0];
         default:          addr_of = i;
      endcase
   endfunction

   function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                  logic signed [32:0] d);
      logic signed [33:0] s;
      s = {{2{a[31]}}, a} + {d[32], d};
      if (s > 34'sd2147483647) begin
         sat_add = 32'sh7FFFFFFF;
      end else if (s < -34'sd2147483648) begin
         sat_add = 32'sh80000000;
      end else begin
         sat_add = s[31:0];
      end
   endfunction

   function automatic logic signed [31:0] pick(kbse_pkg::src_type src,
                                               logic signed [31:0] p_i,
                                               logic signed [31:0] p_ip1,
                                               logic signed [31:0] p_im1,
                                               logic signed [31:0] s_oh,
                                               logic signed [31:0] s_ih);
      case (src)
         kbse_pkg::SRC_PV_IP1: pick = p_ip1;
         kbse_pkg::SRC_PV_IM1: pick = p_im1;
         kbse_pkg::SRC_SUM_OH: pick = s_oh;
         kbse_pkg::SRC_SUM_IH: pick = s_ih;
         default:              pick = p_i;
      endcase
   endfunction

   assign rd_addr  = addr_of(cmd.rd_sel, idx_ff, cnt_ff);
   assign point_ok = {1'b0, idx_ff} < cnt_ff;

   assign flags.op       = op_ff;
   assign flags.kind     = kind_ff;
   assign flags.point_ok = point_ok;
   assign flags.seg_ok   = ({1'b0, idx_ff} + CW'(1)) < cnt_ff;
   assign flags.i_zero   = (idx_ff == '0);
   assign flags.full     = (cnt_ff == CW'(kbse_pkg::MAX_POINTS));
   assign flags.sk_i     = sk_i_ff;
   assign flags.sk_im1   = sk_im1_ff;
   assign flags.ck_i     = ck_i_ff;

   // tables: one write and one registered read each cycle
   always_ff @(posedge clock) begin
      if (cmd.pv_we) begin
         pv_mem[addr_of(cmd.pv_wa, idx_ff, cnt_ff)] <= val_ff;
      end
      if (cmd.oh_we) begin
         oh_mem[addr_of(cmd.oh_wa, idx_ff, cnt_ff)] <=
            pick(cmd.oh_src, pv_i_ff, pv_ip1_ff, pv_im1_ff, sum_oh_ff, sum_ih_ff);
      end
      if (cmd.ih_we) begin
         ih_mem[addr_of(cmd.ih_wa, idx_ff, cnt_ff)] <=
            pick(cmd.ih_src, pv_i_ff, pv_ip1_ff, pv_im1_ff, sum_oh_ff, sum_ih_ff);
      end
      if (cmd.sk_we) begin
         sk_mem[addr_of(cmd.sk_wa, idx_ff, cnt_ff)] <= cmd.sk_wd;
      end
      if (cmd.ck_we) begin
         ck_mem[addr_of(cmd.ck_wa, idx_ff, cnt_ff)] <= cmd.ck_wd;
      end
      pv_rd_ff <= pv_mem[rd_addr];
      oh_rd_ff <= oh_mem[rd_addr];
      ih_rd_ff <= ih_mem[rd_addr];
      sk_rd_ff <= sk_mem[rd_addr];
      ck_rd_ff <= ck_mem[rd_addr];
   end

   assign cnt_in = cmd.cnt_inc ? cnt_ff + CW'(1) : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // lerp unit: product registered, then accumulated in the next cycle
   always_comb begin
      case (cmd.lane)
         2'd1: begin lo_val = c1_ff; hi_val = c2_ff; end
         2'd2: begin lo_val = c2_ff; hi_val = c3_ff; end
         default: begin lo_val = c0_ff; hi_val = c1_ff; end
      endcase
      diff    = {hi_val[31], hi_val} - {lo_val[31], lo_val};
      prod_in = diff * $signed({1'b0, t_ff}) + 51'sd32768;
      add_val = lo_val + prod_ff[47:16];
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         op_ff     <= req_opcode;
         idx_ff    <= req_point_index;
         val_ff    <= req_value_in;
         t_ff      <= (req_position > T_ONE) ? T_ONE : req_position;
         kind_ff   <= req_kind;
         result_ff <= '0;
         status_ff <= kbse_pkg::ST_OK;
      end
      if (cmd.cap_i) begin
         pv_i_ff <= pv_rd_ff;
         oh_i_ff <= oh_rd_ff;
         ih_i_ff <= ih_rd_ff;
         sk_i_ff <= sk_rd_ff;
         ck_i_ff <= ck_rd_ff;
      end
      if (cmd.cap_ip1) begin
         pv_ip1_ff <= pv_rd_ff;
         ih_ip1_ff <= ih_rd_ff;
      end
      if (cmd.cap_im1) begin
         pv_im1_ff <= pv_rd_ff;
         sk_im1_ff <= sk_rd_ff;
      end
      if (cmd.calc_delta) begin
         delta_ff <= {val_ff[31], val_ff} - {pv_i_ff[31], pv_i_ff};
      end
      if (cmd.calc_sum) begin
         sum_oh_ff <= sat_add(oh_i_ff, delta_ff);
         sum_ih_ff <= sat_add(ih_i_ff, delta_ff);
      end
      if (cmd.status_we) begin
         status_ff <= cmd.status_val;
      end
      if (cmd.load_ctl) begin
         c0_ff <= pv_i_ff;
         case (sk_i_ff)
            kbse_pkg::SEG_QUAD: begin
               c1_ff <= oh_i_ff;
               c2_ff <= pv_ip1_ff;
               c3_ff <= pv_ip1_ff;
            end
            kbse_pkg::SEG_CUBIC: begin
               c1_ff <= oh_i_ff;
               c2_ff <= ih_ip1_ff;
               c3_ff <= pv_ip1_ff;
            end
            default: begin
               c1_ff <= pv_ip1_ff;
               c2_ff <= pv_ip1_ff;
               c3_ff <= pv_ip1_ff;
            end
         endcase
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.add) begin
         case (cmd.lane)
            2'd1:    c1_ff <= add_val;
            2'd2:    c2_ff <= add_val;
            default: c0_ff <= add_val;
         endcase
      end
      if (cmd.res_set) begin
         result_ff <= c0_ff;
      end
      if (cmd.rsp_load) begin
         rsp_curve_ff  <= result_ff;
         rsp_sk_ff     <= point_ok ? sk_rd_ff : 2'd0;
         rsp_ck_ff     <= point_ok ? ck_rd_ff : 1'b0;
         rsp_total_ff  <= cnt_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_curve_value      = rsp_curve_ff;
   assign rsp_segment_kind_out = rsp_sk_ff;
   assign rsp_corner_kind_out  = rsp_ck_ff;
   assign rsp_point_total      = rsp_total_ff;
   assign rsp_status           = rsp_status_ff;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the keyframe Bezier spline engine.
// Depends on kbse_pkg and keyframe_bezier_spline_engine; holds its own spline table model.
module tb_top;

   typedef struct packed {
      logic signed [31:0]         curve;
      logic [1:0]                 seg;
      logic                       corner;
      logic [kbse_pkg::CNT_W-1:0] total;
      logic [1:0]                 status;
   } spline_rsp_type;

   // opcodes outside the defined set
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam int         EXP_DEPTH  = 16;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [2:0]                   req_opcode = '0;
   logic [kbse_pkg::IDX_W-1:0]   req_point_index = '0;
   logic signed [31:0]           req_value_in = '0;
   logic [16:0]                  req_position = '0;
   logic [1:0]                   req_kind = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [31:0]           rsp_curve_value;
   logic [1:0]                   rsp_segment_kind_out;
   logic                         rsp_corner_kind_out;
   logic [kbse_pkg::CNT_W-1:0]   rsp_point_total;
   logic [1:0]                   rsp_status;

   // spline table shadow
   logic signed [31:0] key_val [kbse_pkg::MAX_POINTS];
   logic signed [31:0] hin     [kbse_pkg::MAX_POINTS];
   logic signed [31:0] hout    [kbse_pkg::MAX_POINTS];
   logic [1:0]         seg_kind[kbse_pkg::MAX_POINTS];
   logic               corner  [kbse_pkg::MAX_POINTS];
   int                 key_cnt;

   spline_rsp_type exp_fifo [EXP_DEPTH];
   int             exp_wr = 0;
   int             exp_rd = 0;
   int             errors;
   int             quiet_cycles;
   bit             gaps_on;
   bit             hold_rsp;

   keyframe_bezier_spline_engine DUT (.*);

   always #5 clock = ~clock;

   function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                  logic signed [63:0] d);
      logic signed [63:0] s;
      s = 64'(a) + d;
      if (s > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (s < -64'sh80000000) return 32'sh80000000;
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] lerp_q16(logic signed [31:0] a,
                                                   logic signed [31:0] b,
                                                   logic signed [63:0] t);
      logic signed [63:0] d;
      d = 64'(b) - 64'(a);
      d = d * t + 64'sd32768;
      return 32'(64'(a) + (d >>> 16));
   endfunction

   function automatic logic signed [31:0] curve_at(int i, logic signed [63:0] t);
      logic signed [31:0] a, b, c;
      case (seg_kind[i])
         kbse_pkg::SEG_QUAD:
            return lerp_q16(lerp_q16(key_val[i], hout[i], t),
                            lerp_q16(hout[i], key_val[i+1], t), t);
         kbse_pkg::SEG_CUBIC: begin
            a = lerp_q16(key_val[i], hout[i], t);
            b = lerp_q16(hout[i], hin[i+1], t);
            c = lerp_q16(hin[i+1], key_val[i+1], t);
            return lerp_q16(lerp_q16(a, b, t), lerp_q16(b, c, t), t);
         end
         default: return lerp_q16(key_val[i], key_val[i+1], t);
      endcase
   endfunction

   task automatic shape_segment(int i, logic [1:0] k);
      if (k == kbse_pkg::SEG_LINEAR) begin
         seg_kind[i] = kbse_pkg::SEG_LINEAR;
      end else if (k == kbse_pkg::SEG_QUAD) begin
         hout[i] = key_val[i];
         hin[i+1] = key_val[i];
         seg_kind[i] = kbse_pkg::SEG_QUAD;
      end else if (k == kbse_pkg::SEG_CUBIC) begin
         hout[i] = key_val[i];
         hin[i+1] = key_val[i+1];
         seg_kind[i] = kbse_pkg::SEG_CUBIC;
      end
   endtask

   task automatic apply_spline_op(logic [2:0] op, int i, logic signed [31:0] v,
                                  logic [16:0] pos, logic [1:0] k);
      spline_rsp_type r;
      logic signed [63:0] t, delta;
      bit pt_ok, sg_ok;
      r = '0;
      pt_ok = i < key_cnt;
      sg_ok = i + 1 < key_cnt;
      t = (pos > 17'd65536) ? 64'sd65536 : 64'(pos);
      case (op)
         kbse_pkg::OP_ADD_POINT: begin
            if (key_cnt >= kbse_pkg::MAX_POINTS) begin
               r.status = kbse_pkg::ST_FULL;
            end else begin
               key_val[key_cnt] = v;
               seg_kind[key_cnt] = kbse_pkg::SEG_LINEAR;
               corner[key_cnt] = 1'b0;
               key_cnt++;
            end
         end
         kbse_pkg::OP_SET_VALUE: begin
            if (!pt_ok) begin
               r.status = kbse_pkg::ST_RANGE;
            end else begin
               delta = 64'(v) - 64'(key_val[i]);
               key_val[i] = v;
               if (sg_ok && seg_kind[i] != kbse_pkg::SEG_LINEAR) begin
                  hout[i] = sat_add(hout[i], delta);
                  if (seg_kind[i] == kbse_pkg::SEG_QUAD) hin[i+1] = hout[i];
               end
               if (i > 0 && seg_kind[i-1] != kbse_pkg::SEG_LINEAR) begin
                  hin[i] = sat_add(hin[i], delta);
                  if (seg_kind[i-1] == kbse_pkg::SEG_QUAD) hout[i-1] = hin[i];
               end
            end
         end
         kbse_pkg::OP_SET_SEG: begin
            if (!sg_ok) r.status = kbse_pkg::ST_RANGE;
            else shape_segment(i, k);
         end
         kbse_pkg::OP_SET_CORNER: begin
            if (!pt_ok) begin
               r.status = kbse_pkg::ST_RANGE;
            end else if (k <= 2'd1 && corner[i] != k[0]) begin
               corner[i] = k[0];
               if (k == 2'd1) begin
                  if (i > 0 && seg_kind[i-1] != kbse_pkg::SEG_CUBIC)
                     shape_segment(i - 1, kbse_pkg::SEG_CUBIC);
                  if (sg_ok && seg_kind[i] != kbse_pkg::SEG_CUBIC)
                     shape_segment(i, kbse_pkg::SEG_CUBIC);
                  if (i > 0) hin[i] = key_val[i];
                  if (sg_ok) hout[i] = key_val[i];
               end
            end
         end
         kbse_pkg::OP_EVALUATE: begin
            if (!sg_ok) r.status = kbse_pkg::ST_RANGE;
            else r.curve = curve_at(i, t);
         end
         kbse_pkg::OP_READ_TYPES: begin
            if (!pt_ok) r.status = kbse_pkg::ST_RANGE;
         end
         default: ;
      endcase
      if (i < key_cnt) begin
         r.seg = seg_kind[i];
         r.corner = corner[i];
      end
      r.total = key_cnt[kbse_pkg::CNT_W-1:0];
      exp_fifo[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
   endtask

   task automatic send_op(logic [2:0] op, int i, logic signed [31:0] v,
                          logic [16:0] pos, logic [1:0] k);
      int w;
      bit acc;
      w = gaps_on ? $urandom_range(0, 3) : 0;
      if (w > 0) begin
         req_valid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_point_index <= i[kbse_pkg::IDX_W-1:0];
      req_value_in <= v;
      req_position <= pos;
      req_kind <= k;
      // sample ready mid-cycle, where it holds the value seen at the next edge
      do begin
         @(negedge clock);
         acc = req_ready;
         @(posedge clock);
      end while (!acc);
      apply_spline_op(op, int'(i[kbse_pkg::IDX_W-1:0]), v, pos, k);
   endtask

   task automatic drain_rsp();
      req_valid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
   endtask

   // response acceptance: random stalls, plus one long hold-off on request
   initial begin
      int w;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         w = gaps_on ? $urandom_range(0, 3) : 0;
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready) && !hold_rsp);
      end
   end

   always @(posedge clock) begin
      spline_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_wr == exp_rd) begin
            $display("%0t: unexpected response, curve %h", $time, rsp_curve_value);
            errors++;
         end else begin
            e = exp_fifo[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_curve_value !== e.curve) begin
               $display("%0t: curve_value exp %h got %h", $time, e.curve, rsp_curve_value);
               errors++;
            end
            if (rsp_segment_kind_out !== e.seg) begin
               $display("%0t: segment_kind exp %0d got %0d", $time, e.seg,
                        rsp_segment_kind_out);
               errors++;
            end
            if (rsp_corner_kind_out !== e.corner) begin
               $display("%0t: corner_kind exp %0d got %0d", $time, e.corner,
                        rsp_corner_kind_out);
               errors++;
            end
            if (rsp_point_total !== e.total) begin
               $display("%0t: point_total exp %0d got %0d", $time, e.total, rsp_point_total);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_status);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic test_empty_table();
      send_op(kbse_pkg::OP_READ_TYPES, 0, 0, 0, 0);
      send_op(kbse_pkg::OP_SET_VALUE, 0, 32'sd7, 0, 0);
      send_op(kbse_pkg::OP_EVALUATE, 0, 0, 17'd100, 0);
      send_op(kbse_pkg::OP_SET_CORNER, 0, 0, 0, 1);
      send_op(kbse_pkg::OP_SET_SEG, 63, 0, 0, 2);
   endtask

   task automatic test_directed_ops();
      send_op(kbse_pkg::OP_ADD_POINT, 0, 32'sh7FFFFFFF, 0, 0);
      send_op(kbse_pkg::OP_ADD_POINT, 0, 32'sh80000000, 0, 0);
      send_op(kbse_pkg::OP_ADD_POINT, 0, 32'sd0, 0, 0);
      send_op(kbse_pkg::OP_ADD_POINT, 0, 32'sd12345, 0, 0);
      send_op(kbse_pkg::OP_SET_SEG, 0, 0, 0, kbse_pkg::SEG_QUAD);
      send_op(kbse_pkg::OP_SET_SEG, 1, 0, 0, kbse_pkg::SEG_CUBIC);
      send_op(kbse_pkg::OP_SET_SEG, 2, 0, 0, 2'd3);    // unknown kind: ignore
      send_op(kbse_pkg::OP_SET_SEG, 3, 0, 0, kbse_pkg::SEG_CUBIC); // last point: bad segment
      send_op(kbse_pkg::OP_EVALUATE, 0, 0, 17'd0, 0);
      send_op(kbse_pkg::OP_EVALUATE, 1, 0, 17'd65536, 0);
      send_op(kbse_pkg::OP_EVALUATE, 1, 0, 17'h1FFFF, 0);
      send_op(kbse_pkg::OP_EVALUATE, 0, 0, 17'd32768, 0);
      send_op(kbse_pkg::OP_SET_VALUE, 1, -32'sd5, 0, 0); // handle shift saturates
      send_op(kbse_pkg::OP_SET_CORNER, 2, 0, 0, 1);
      send_op(kbse_pkg::OP_SET_CORNER, 2, 0, 0, 1);    // same corner: no change
      send_op(kbse_pkg::OP_SET_CORNER, 2, 0, 0, 3);
      send_op(OP_SPARE_A, 1, 32'sd1, 0, 0);
      send_op(OP_SPARE_B, 2, 32'sd1, 0, 0);
   endtask

   task automatic send_random_op();
      int sel, i;
      logic [2:0] op;
      logic signed [31:0] v;
      logic [16:0] pos;
      sel = $urandom_range(0, 99);
      if (key_cnt < 2 || sel < 10) op = kbse_pkg::OP_ADD_POINT;
      else if (sel < 12) op = $urandom_range(0, 1) ? OP_SPARE_B : OP_SPARE_A;
      else op = 3'($urandom_range(kbse_pkg::OP_SET_VALUE, kbse_pkg::OP_READ_TYPES));
      if ($urandom_range(0, 9) < 9 && key_cnt > 0) i = $urandom_range(0, key_cnt);
      else i = $urandom_range(0, kbse_pkg::MAX_POINTS - 1);
      case ($urandom_range(0, 7))
         0: v = 32'sh7FFFFFFF;
         1: v = 32'sh80000000;
         2: v = $signed($urandom_range(0, 2000)) - 1000;
         default: v = $urandom;
      endcase
      case ($urandom_range(0, 9))
         0: pos = 17'd0;
         1: pos = 17'd65536;
         2: pos = 17'($urandom_range(65537, 131071));
         default: pos = 17'($urandom_range(0, 65536));
      endcase
      send_op(op, i, v, pos, 2'($urandom_range(0, 3)));
   endtask

   task automatic test_random_ops(int n);
      repeat (n) send_random_op();
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      repeat (12) send_random_op();
      drain_rsp();
   endtask

   task automatic test_table_full();
      while (key_cnt < kbse_pkg::MAX_POINTS)
         send_op(kbse_pkg::OP_ADD_POINT, 0, $urandom, 0, 0);
      send_op(kbse_pkg::OP_ADD_POINT, 0, 32'sd1, 0, 0);
      send_op(kbse_pkg::OP_EVALUATE, kbse_pkg::MAX_POINTS - 2, 0, 17'd40000, 0);
      send_op(kbse_pkg::OP_SET_CORNER, kbse_pkg::MAX_POINTS - 1, 0, 0, 1);
      repeat (30) send_random_op();
   endtask

   initial begin
      errors = 0;
      key_cnt = 0;
      gaps_on = 1'b1;
      hold_rsp = 1'b0;
      for (int j = 0; j < kbse_pkg::MAX_POINTS; j++) begin
         seg_kind[j] = kbse_pkg::SEG_LINEAR;
         corner[j] = 1'b0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_directed_ops();
      drain_rsp();
      test_random_ops(200);
      gaps_on = 1'b0;
      test_random_ops(80);
      gaps_on = 1'b1;
      test_backpressure();
      test_random_ops(200);
      test_table_full();
      drain_rsp();
      repeat (40) @(posedge clock);
      if (errors == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end
endmodule

>>> keyframe_bezier_spline_engine.f
rtl/kbse_pkg.sv
rtl/kbse_ctrl.sv
rtl/kbse_dp.sv
rtl/keyframe_bezier_spline_engine.sv
dv/tb_top.sv
